// File: hdl/mmc1_pkg.sv
// shared types and codes of the mmc1 bank mapper
package mmc1_pkg;

    // access kinds carried on the input tuser
    localparam logic [1:0] MODE_CPU_RD = 2'd0;
    localparam logic [1:0] MODE_CPU_WR = 2'd1;
    localparam logic [1:0] MODE_PPU_RD = 2'd2;
    localparam logic [1:0] MODE_PPU_WR = 2'd3;

    // target memories carried on the output tuser
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_PRG  = 2'd1;
    localparam logic [1:0] TGT_CHR  = 2'd2;
    localparam logic [1:0] TGT_NT   = 2'd3;

    // configuration register indexes
    localparam logic REG_PRG_COUNT = 1'b0;
    localparam logic REG_CHR_COUNT = 1'b1;

    localparam int APB_ADDR_W = 3;

    // page rebuild operations, in the order they run
    localparam logic [1:0] OP_CHR0 = 2'd0;
    localparam logic [1:0] OP_CHR1 = 2'd1;
    localparam logic [1:0] OP_PRG0 = 2'd2;
    localparam logic [1:0] OP_PRG1 = 2'd3;

    // serial register selects, from address bits 14..13
    localparam logic [1:0] SEL_CTRL   = 2'd0;
    localparam logic [1:0] SEL_CHR_LO = 2'd1;
    localparam logic [1:0] SEL_CHR_HI = 2'd2;
    localparam logic [1:0] SEL_PRG    = 2'd3;

    // prg banking modes, control bits 3..2
    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

    // mirroring, control bits 1..0
    localparam logic [1:0] MIR_LOWER = 2'd0;
    localparam logic [1:0] MIR_UPPER = 2'd1;
    localparam logic [1:0] MIR_VERT  = 2'd2;
    localparam logic [1:0] MIR_HORZ  = 2'd3;

    localparam logic [4:0] SHIFT_EMPTY     = 5'h10;
    localparam logic [4:0] CTRL_RESET      = 5'h0C;
    localparam logic [4:0] CTRL_FIX_LAST   = 5'h0C;
    localparam logic [5:0] COUNT_RESET     = 6'd2;
    localparam logic [5:0] MAX_PRG_BANKS   = 6'd32;
    localparam logic [5:0] MAX_CHR_BANKS   = 6'd32;
    localparam logic [5:0] PALETTE_PAGE    = 6'h3F;
    localparam int         MOD_STEPS       = 5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] bus_address;
        logic [7:0]  write_value;
        logic [31:0] cycle_stamp;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  target;
        logic [18:0] mem_address;
        logic        write_enable;
        logic [7:0]  write_data;
    } t_out_word;

    typedef struct packed {
        logic       in_load;
        logic       exec;
        logic       pass_start;
        logic       mod_load;
        logic       mod_step;
        logic       page_wr;
        logic [1:0] op;
    } t_dp_cmd;

endpackage

// File: hdl/mmc1_ctrl.sv
// controller state machine of the mmc1 bank mapper
module mmc1_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_cfg_wr,
    input  logic                 i_reload,
    output mmc1_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;

    localparam int STEP_W = $clog2(mmc1_pkg::MOD_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(mmc1_pkg::MOD_STEPS - 1);

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_op, n_op;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    logic              out_free;
    logic              accept;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && !r_pend && !i_cfg_wr;
    assign accept     = o_in_ready && i_in_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_step      = r_step;
        o_cmd       = '0;
        o_cmd.op    = r_op;
        o_cmd.in_load = accept;
        case (r_state)
            S_IDLE: begin
                if (r_pend || i_cfg_wr) begin
                    n_state = S_LOAD;
                end else if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state = (i_reload || r_pend) ? S_LOAD : S_IDLE;
                end
            end
            S_LOAD: begin
                o_cmd.mod_load   = 1'b1;
                o_cmd.pass_start = (r_op == mmc1_pkg::OP_CHR0);
                n_step  = '0;
                n_state = S_STEP;
            end
            S_STEP: begin
                o_cmd.mod_step = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.page_wr = 1'b1;
                n_op = r_op + 1'b1;
                n_state = (r_op == mmc1_pkg::OP_PRG1 && !r_pend) ? S_IDLE : S_LOAD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // a bank count write during a pass asks for another full pass
    assign n_pend = i_cfg_wr || (r_pend && !o_cmd.pass_start);
    assign n_out_valid = o_cmd.exec ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_op        <= mmc1_pkg::OP_CHR0;
            r_step      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_step      <= n_step;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: hdl/mmc1_dp.sv
// datapath of the mmc1 bank mapper: registers, remainder unit, address translation
module mmc1_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mmc1_pkg::t_dp_cmd     i_cmd,
    input  mmc1_pkg::t_in_word    i_word,
    input  logic                  i_cfg_wr,
    input  logic                  i_cfg_idx,
    input  logic [5:0]            i_cfg_data,
    output logic                  o_reload,
    output mmc1_pkg::t_out_word   o_result,
    output logic [5:0]            o_prg_count,
    output logic [5:0]            o_chr_count
);

    function automatic logic [5:0] clamp_count(input logic [5:0] n, input logic [5:0] lim);
        return (n > lim) ? lim : n;
    endfunction

    // configuration and mapper registers
    logic [5:0]  r_prg_count, r_chr_count;
    logic [4:0]  r_shift, r_ctrl, r_prg_sel, r_chr_lo, r_chr_hi;
    logic [31:0] r_last;
    // page tables and pass snapshot
    logic [4:0]  r_prg_page [2];
    logic [4:0]  r_chr_page [2];
    logic [5:0]  r_np, r_nc;
    // remainder unit, remainder always below the divisor so five bits suffice
    logic [4:0]  r_rem;
    logic [5:0]  r_div;
    logic [4:0]  r_quo;
    // latched access and registered result
    mmc1_pkg::t_in_word  r_word;
    mmc1_pkg::t_out_word r_result, n_result;

    logic [5:0]  np_live, nc_live, div_sel;
    logic [4:0]  dividend;
    logic [5:0]  trial;
    logic [31:0] delta;
    logic        close_wr, reg_wr, wr_taken;
    logic [4:0]  shifted;
    logic [13:0] pa;
    logic        nt_bit;

    assign np_live = clamp_count(r_prg_count, mmc1_pkg::MAX_PRG_BANKS);
    assign nc_live = clamp_count(r_chr_count, mmc1_pkg::MAX_CHR_BANKS);

    // op 0 starts the pass, so it sees the live count rather than the snapshot
    always_comb begin
        if (i_cmd.op == mmc1_pkg::OP_CHR0) begin
            div_sel = nc_live;
        end else if (i_cmd.op[1]) begin
            div_sel = r_np;
        end else begin
            div_sel = r_nc;
        end
    end

    always_comb begin
        dividend = '0;
        case (i_cmd.op)
            mmc1_pkg::OP_CHR0: begin
                dividend = r_ctrl[4] ? r_chr_lo : {r_chr_lo[4:1], 1'b0};
            end
            mmc1_pkg::OP_CHR1: begin
                dividend = r_ctrl[4] ? r_chr_hi : {r_chr_lo[4:1], 1'b1};
            end
            mmc1_pkg::OP_PRG0: begin
                case (r_ctrl[3:2])
                    mmc1_pkg::PRG_MODE_FIX_FIRST: dividend = '0;
                    mmc1_pkg::PRG_MODE_FIX_LAST:  dividend = r_prg_sel;
                    default:                      dividend = {r_prg_sel[4:1], 1'b0};
                endcase
            end
            default: begin
                case (r_ctrl[3:2])
                    mmc1_pkg::PRG_MODE_FIX_FIRST: dividend = r_prg_sel;
                    // last bank, always below the count
                    mmc1_pkg::PRG_MODE_FIX_LAST:  dividend = 5'(r_np - 6'd1);
                    default:                      dividend = {r_prg_sel[4:1], 1'b1};
                endcase
            end
        endcase
    end

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {r_rem, r_quo[4]};

    // serial register port
    assign delta    = r_word.cycle_stamp - r_last;
    assign close_wr = (delta[31:1] == '0);
    assign reg_wr   = (r_word.mode == mmc1_pkg::MODE_CPU_WR) && r_word.bus_address[15];
    assign wr_taken = reg_wr && !close_wr;
    assign shifted  = {r_word.write_value[0], r_shift[4:1]};
    assign o_reload = wr_taken && (r_word.write_value[7] || r_shift[0]);

    // address translation
    assign pa = r_word.bus_address[13:0];

    always_comb begin
        case (r_ctrl[1:0])
            mmc1_pkg::MIR_LOWER: nt_bit = 1'b0;
            mmc1_pkg::MIR_UPPER: nt_bit = 1'b1;
            mmc1_pkg::MIR_VERT:  nt_bit = pa[10];
            default:             nt_bit = pa[11];
        endcase
    end

    always_comb begin
        n_result = '0;
        case (r_word.mode)
            mmc1_pkg::MODE_CPU_RD: begin
                if (r_word.bus_address[15]) begin
                    n_result.target      = mmc1_pkg::TGT_PRG;
                    n_result.mem_address = {r_prg_page[r_word.bus_address[14]],
                                            r_word.bus_address[13:0]};
                end
            end
            mmc1_pkg::MODE_CPU_WR: begin
                n_result = '0;
            end
            default: begin
                if (!pa[13]) begin
                    if (r_chr_count == '0) begin
                        // chr ram, read and written directly
                        n_result.target       = mmc1_pkg::TGT_CHR;
                        n_result.mem_address  = {6'd0, pa[12:0]};
                        n_result.write_enable = r_word.mode[0];
                        n_result.write_data   = r_word.mode[0] ? r_word.write_value : 8'd0;
                    end else if (!r_word.mode[0]) begin
                        n_result.target      = mmc1_pkg::TGT_CHR;
                        n_result.mem_address = {2'd0, r_chr_page[pa[12]], pa[11:0]};
                    end
                end else if (pa[13:8] != mmc1_pkg::PALETTE_PAGE) begin
                    n_result.target       = mmc1_pkg::TGT_NT;
                    n_result.mem_address  = {8'd0, nt_bit, pa[9:0]};
                    n_result.write_enable = r_word.mode[0];
                    n_result.write_data   = r_word.mode[0] ? r_word.write_value : 8'd0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_count <= mmc1_pkg::COUNT_RESET;
            r_chr_count <= mmc1_pkg::COUNT_RESET;
            r_shift     <= mmc1_pkg::SHIFT_EMPTY;
            r_ctrl      <= mmc1_pkg::CTRL_RESET;
            r_prg_sel   <= '0;
            r_chr_lo    <= '0;
            r_chr_hi    <= '0;
            r_last      <= '0;
        end else begin
            if (i_cfg_wr) begin
                if (i_cfg_idx == mmc1_pkg::REG_PRG_COUNT) begin
                    r_prg_count <= i_cfg_data;
                end else begin
                    r_chr_count <= i_cfg_data;
                end
            end
            if (i_cmd.exec && wr_taken) begin
                r_last <= r_word.cycle_stamp;
                if (r_word.write_value[7]) begin
                    r_shift <= mmc1_pkg::SHIFT_EMPTY;
                    r_ctrl  <= r_ctrl | mmc1_pkg::CTRL_FIX_LAST;
                end else if (r_shift[0]) begin
                    r_shift <= mmc1_pkg::SHIFT_EMPTY;
                    case (r_word.bus_address[14:13])
                        mmc1_pkg::SEL_CTRL:   r_ctrl    <= shifted;
                        mmc1_pkg::SEL_CHR_LO: r_chr_lo  <= shifted;
                        mmc1_pkg::SEL_CHR_HI: r_chr_hi  <= shifted;
                        default:              r_prg_sel <= shifted;
                    endcase
                end else begin
                    r_shift <= shifted;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_word <= i_word;
        end
        if (i_cmd.exec) begin
            r_result <= n_result;
        end
        if (i_cmd.pass_start) begin
            r_np <= np_live;
            r_nc <= nc_live;
        end
        if (i_cmd.mod_load) begin
            r_rem <= '0;
            r_quo <= dividend;
            r_div <= div_sel;
        end else if (i_cmd.mod_step) begin
            r_rem <= (trial >= r_div) ? 5'(trial - r_div) : trial[4:0];
            r_quo <= {r_quo[3:0], 1'b0};
        end
        // a zero count leaves its pages as they were
        if (i_cmd.page_wr && r_div != '0) begin
            case (i_cmd.op)
                mmc1_pkg::OP_CHR0: r_chr_page[0] <= r_rem;
                mmc1_pkg::OP_CHR1: r_chr_page[1] <= r_rem;
                mmc1_pkg::OP_PRG0: r_prg_page[0] <= r_rem;
                default:           r_prg_page[1] <= r_rem;
            endcase
        end
    end

    assign o_result    = r_result;
    assign o_prg_count = r_prg_count;
    assign o_chr_count = r_chr_count;

endmodule

// File: hdl/mmc1_bank_mapper_unit.sv
// top level of the mmc1 bank mapper: stream ports, register port, controller and datapath
//
// each word on the slave stream is one cpu or ppu bus access; the block answers every
// word with exactly one word on the master stream naming the target memory (none, prg
// rom, chr memory or nametable vram), the byte address within it and, for writes that
// reach a memory, the write enable and data. cpu writes at 0x8000 and above feed the
// five-write serial port of the mapper and give a word with no target. the result is
// registered once its access is latched and the master side is free, and the next access
// is taken while that result still waits for the sink. when a serial write completes a
// register load, a reset write (bit 7 set) arrives, or a bank count is written through
// the register port, the four page numbers are rebuilt by one shared shift-and-subtract
// remainder unit: four remainders, each a load step, five shift-and-subtract steps and
// a write step, and no access is taken while it runs. the same rebuild runs straight
// after reset. bank counts sit at byte addresses 0 (prg, 16kb banks) and 4 (chr, 4kb
// banks); a chr count of zero selects 8kb chr ram
module mmc1_bank_mapper_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [55:0]                       s_axis_tdata,  // bus_address, write_value, cycle_stamp
    input  logic [1:0]                        s_axis_tuser,  // mode
    // master stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,  // mem_address, write_enable, write_data
    output logic [1:0]                        m_axis_tuser,  // target
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mmc1_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    mmc1_pkg::t_dp_cmd   cmd;
    mmc1_pkg::t_in_word  in_word;
    mmc1_pkg::t_out_word result;
    logic                reload;
    logic                cfg_wr;
    logic                cfg_idx;
    logic [5:0]          prg_count, chr_count;

    // register port: no wait states, word index from address bit 2
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[2];
    assign prdata  = (cfg_idx == mmc1_pkg::REG_CHR_COUNT) ? {26'd0, chr_count}
                                                          : {26'd0, prg_count};

    // unpack the incoming word
    assign in_word.mode        = s_axis_tuser;
    assign in_word.bus_address = s_axis_tdata[15:0];
    assign in_word.write_value = s_axis_tdata[23:16];
    assign in_word.cycle_stamp = s_axis_tdata[55:24];

    // pack the outgoing word, zero pad in the top four bits
    assign m_axis_tuser = result.target;
    assign m_axis_tdata = {4'd0, result.write_data, result.write_enable, result.mem_address};

    mmc1_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_cfg_wr    (cfg_wr),
        .i_reload    (reload),
        .o_cmd       (cmd)
    );

    mmc1_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_word      (in_word),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (pwdata[5:0]),
        .o_reload    (reload),
        .o_result    (result),
        .o_prg_count (prg_count),
        .o_chr_count (chr_count)
    );

endmodule

// File: hdl/mmc1_chk.sv
// port-level checker of the mmc1 bank mapper and its bind
module mmc1_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] i_m_tdata,
    input logic [1:0]  i_m_tuser,
    input logic        i_psel,
    input logic        i_penable,
    input logic        i_pwrite
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("stalled result word changed");

    // no target means an all-zero word
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser == mmc1_pkg::TGT_NONE |-> i_m_tdata == '0)
        else $error("word with no target carries data");

    // only chr ram and nametable accesses are written
    a_we_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[19] |->
        i_m_tuser == mmc1_pkg::TGT_CHR || i_m_tuser == mmc1_pkg::TGT_NT)
        else $error("write enable on a read-only target");

    // one access at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("access taken while the previous one is in work");

    // a bank count write starts a page rebuild
    a_busy_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite |=> !i_s_tready)
        else $error("access taken during a page rebuild");

endmodule

bind mmc1_bank_mapper_unit mmc1_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser),
    .i_psel     (psel),
    .i_penable  (penable),
    .i_pwrite   (pwrite)
);

// File: dv/mapper_checker.sv
`timescale 1ns / 1ps
// watches both streams and the register port, predicts each translated access and compares
module mapper_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [55:0]                     s_axis_tdata,  // bus_address, write_value, cycle_stamp
    input  logic [1:0]                      s_axis_tuser,  // mode
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [31:0]                     m_axis_tdata,  // mem_address, write_enable, write_data
    input  logic [1:0]                      m_axis_tuser,  // target
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mmc1_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    input  logic                            pready,
    output int                              o_fail_count,
    output int                              o_words_due
);

    logic [5:0]  prg_count;
    logic [5:0]  chr_count;
    logic [4:0]  shift_reg;
    logic [4:0]  ctrl_bits;
    logic [4:0]  prg_sel;
    logic [4:0]  chr_sel_lo;
    logic [4:0]  chr_sel_hi;
    logic [31:0] last_stamp;
    logic [4:0]  prg_pg [2];
    logic [4:0]  chr_pg [2];
    mmc1_pkg::t_out_word mapped_words [$];
    mmc1_pkg::t_in_word  seen_in;
    mmc1_pkg::t_out_word seen_out;
    mmc1_pkg::t_out_word due_word;
    int          mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    initial o_words_due = 0;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at %0t: got 0x%0h, want 0x%0h", field, $time, got, want);
        mismatch_count++;
    endtask

    function automatic void rebuild_pages();
        int unsigned nc;
        int unsigned np;
        nc = (chr_count > mmc1_pkg::MAX_CHR_BANKS) ? mmc1_pkg::MAX_CHR_BANKS : chr_count;
        np = (prg_count > mmc1_pkg::MAX_PRG_BANKS) ? mmc1_pkg::MAX_PRG_BANKS : prg_count;
        if (nc > 0) begin
            if (ctrl_bits[4]) begin
                chr_pg[0] = 5'(chr_sel_lo % nc);
                chr_pg[1] = 5'(chr_sel_hi % nc);
            end else begin
                chr_pg[0] = 5'((chr_sel_lo & 5'h1E) % nc);
                chr_pg[1] = 5'((chr_sel_lo | 5'h01) % nc);
            end
        end
        if (np > 0) begin
            case (ctrl_bits[3:2])
                mmc1_pkg::PRG_MODE_FIX_FIRST: begin
                    prg_pg[0] = 5'd0;
                    prg_pg[1] = 5'(prg_sel % np);
                end
                mmc1_pkg::PRG_MODE_FIX_LAST: begin
                    prg_pg[0] = 5'(prg_sel % np);
                    prg_pg[1] = 5'(np - 1);
                end
                default: begin
                    prg_pg[0] = 5'((prg_sel & 5'h1E) % np);
                    prg_pg[1] = 5'((prg_sel | 5'h01) % np);
                end
            endcase
        end
    endfunction

    function automatic logic [10:0] mirror_nametable(input logic [11:0] a);
        case (ctrl_bits[1:0])
            mmc1_pkg::MIR_LOWER: return {1'b0, a[9:0]};
            mmc1_pkg::MIR_UPPER: return {1'b1, a[9:0]};
            mmc1_pkg::MIR_VERT:  return {a[10], a[9:0]};
            default:             return {a[11], a[9:0]};
        endcase
    endfunction

    function automatic void serial_port_write(input logic [15:0] addr, input logic [7:0] value,
                                              input logic [31:0] stamp);
        logic [31:0] gap;
        logic        full;
        gap = stamp - last_stamp;
        if (gap < 32'd2)
            return;
        last_stamp = stamp;
        if (value[7]) begin
            shift_reg = mmc1_pkg::SHIFT_EMPTY;
            ctrl_bits |= mmc1_pkg::CTRL_FIX_LAST;
            rebuild_pages();
            return;
        end
        full = shift_reg[0];
        shift_reg = {value[0], shift_reg[4:1]};
        if (!full)
            return;
        case (addr[14:13])
            mmc1_pkg::SEL_CTRL:   ctrl_bits = shift_reg;
            mmc1_pkg::SEL_CHR_LO: chr_sel_lo = shift_reg;
            mmc1_pkg::SEL_CHR_HI: chr_sel_hi = shift_reg;
            default:              prg_sel = shift_reg;
        endcase
        rebuild_pages();
        shift_reg = mmc1_pkg::SHIFT_EMPTY;
    endfunction

    function automatic mmc1_pkg::t_out_word translate_access(input mmc1_pkg::t_in_word acc);
        mmc1_pkg::t_out_word res;
        logic [13:0]         ppu_addr;
        res = '0;
        ppu_addr = acc.bus_address[13:0];
        case (acc.mode)
            mmc1_pkg::MODE_CPU_RD: begin
                if (acc.bus_address[15]) begin
                    res.target = mmc1_pkg::TGT_PRG;
                    res.mem_address = {prg_pg[acc.bus_address[14]], acc.bus_address[13:0]};
                end
            end
            mmc1_pkg::MODE_CPU_WR: begin
                if (acc.bus_address[15])
                    serial_port_write(acc.bus_address, acc.write_value, acc.cycle_stamp);
            end
            default: begin
                if (!ppu_addr[13]) begin
                    if (chr_count == 6'd0) begin
                        res.target = mmc1_pkg::TGT_CHR;
                        res.mem_address = 19'(ppu_addr[12:0]);
                        if (acc.mode == mmc1_pkg::MODE_PPU_WR) begin
                            res.write_enable = 1'b1;
                            res.write_data = acc.write_value;
                        end
                    end else if (acc.mode == mmc1_pkg::MODE_PPU_RD) begin
                        res.target = mmc1_pkg::TGT_CHR;
                        res.mem_address = 19'({chr_pg[ppu_addr[12]], ppu_addr[11:0]});
                    end
                end else if (ppu_addr[13:8] != mmc1_pkg::PALETTE_PAGE) begin
                    res.target = mmc1_pkg::TGT_NT;
                    res.mem_address = 19'(mirror_nametable(ppu_addr[11:0]));
                    if (acc.mode == mmc1_pkg::MODE_PPU_WR) begin
                        res.write_enable = 1'b1;
                        res.write_data = acc.write_value;
                    end
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            prg_count = mmc1_pkg::COUNT_RESET;
            chr_count = mmc1_pkg::COUNT_RESET;
            shift_reg = mmc1_pkg::SHIFT_EMPTY;
            ctrl_bits = mmc1_pkg::CTRL_RESET;
            prg_sel = '0;
            chr_sel_lo = '0;
            chr_sel_hi = '0;
            last_stamp = '0;
            prg_pg[0] = '0;
            prg_pg[1] = '0;
            chr_pg[0] = '0;
            chr_pg[1] = '0;
            rebuild_pages();
            mapped_words.delete();
        end else begin
            // results first, so a word accepted at this edge cannot match a result at it
            if (m_axis_tvalid && m_axis_tready) begin
                seen_out.target = m_axis_tuser;
                seen_out.mem_address = m_axis_tdata[18:0];
                seen_out.write_enable = m_axis_tdata[19];
                seen_out.write_data = m_axis_tdata[27:20];
                if (mapped_words.size() == 0) begin
                    report_mismatch("word with none due", 32'(seen_out.target), 32'd0);
                end else begin
                    due_word = mapped_words.pop_front();
                    if (seen_out.target != due_word.target)
                        report_mismatch("target", 32'(seen_out.target), 32'(due_word.target));
                    if (seen_out.mem_address != due_word.mem_address)
                        report_mismatch("mem_address", 32'(seen_out.mem_address),
                                        32'(due_word.mem_address));
                    if (seen_out.write_enable != due_word.write_enable)
                        report_mismatch("write_enable", 32'(seen_out.write_enable),
                                        32'(due_word.write_enable));
                    if (seen_out.write_data != due_word.write_data)
                        report_mismatch("write_data", 32'(seen_out.write_data),
                                        32'(due_word.write_data));
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == mmc1_pkg::REG_PRG_COUNT)
                    prg_count = pwdata[5:0];
                else
                    chr_count = pwdata[5:0];
                rebuild_pages();
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen_in.mode = s_axis_tuser;
                seen_in.bus_address = s_axis_tdata[15:0];
                seen_in.write_value = s_axis_tdata[23:16];
                seen_in.cycle_stamp = s_axis_tdata[55:24];
                mapped_words.push_back(translate_access(seen_in));
            end
        end
        o_words_due <= mapped_words.size();
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// top of the mmc1 bank mapper bench: clock, reset, stimulus, register writes and verdict
module testbench;

    // generous bound for ~1950 words, plus phase pauses
    localparam int CYCLE_LIMIT   = 400000;
    // longer than the page rebuild after reset or a count write
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_WORDS   = 240;
    localparam int PHASES        = 8;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [55:0]                     s_axis_tdata = '0;  // bus_address, write_value, cycle_stamp
    logic [1:0]                      s_axis_tuser = mmc1_pkg::MODE_CPU_RD;  // mode
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [31:0]                     m_axis_tdata;  // mem_address, write_enable, write_data
    logic [1:0]                      m_axis_tuser;  // target
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [mmc1_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]                     pwdata = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    int                    fail_total;
    int                    words_due;
    int                    words_sent = 0;
    int                    burst_left = 0;
    int unsigned           cycle_count = 0;
    logic [31:0]           bus_stamp = '0;
    logic [7:0]            sink_tick = '0;
    logic [1:0]            sink_style = '0;

    // bank counts per phase: extremes, zero (chr ram / prg pages frozen) and clamped values
    logic [5:0] prg_counts [PHASES] = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd8, 6'd0, 6'd17, 6'd2};
    logic [5:0] chr_counts [PHASES] = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd0, 6'd5, 6'd32, 6'd2};

    always #10 i_clk = ~i_clk;

    mmc1_bank_mapper_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    mapper_checker mapper_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_fail_count  (fail_total),
        .o_words_due   (words_due)
    );

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // sink back-pressure: the style is redrawn when sink_tick[6:0] is zero, style 0 never stalls
    always @(posedge i_clk) begin
        sink_tick <= sink_tick + 8'd1;
        if (sink_tick[6:0] == 7'd0)
            sink_style <= 2'($urandom_range(0, 3));
        case (sink_style)
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2: m_axis_tready <= (sink_tick[1:0] == 2'd0);
            default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // one access word; the source works in bursts with idle gaps between them
    task automatic send_access(input logic [1:0] kind, input logic [15:0] addr,
                               input logic [7:0] value, input logic [31:0] stamp);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {stamp, value, addr};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        burst_left--;
        words_sent++;
    endtask

    // cpu write, with the cycle stamp moved on by the given step (wraps modulo 2^32)
    task automatic cpu_write(input logic [15:0] addr, input logic [7:0] value,
                             input int unsigned step);
        bus_stamp = bus_stamp + step;
        send_access(mmc1_pkg::MODE_CPU_WR, addr, value, bus_stamp);
    endtask

    // any access other than a cpu write; stamps of these do not matter
    task automatic memory_access();
        logic [1:0]  kind;
        logic [15:0] addr;
        case ($urandom_range(0, 2))
            0: kind = mmc1_pkg::MODE_CPU_RD;
            1: kind = mmc1_pkg::MODE_PPU_RD;
            default: kind = mmc1_pkg::MODE_PPU_WR;
        endcase
        addr = 16'($urandom);
        // most cpu reads go to prg rom
        if (kind == mmc1_pkg::MODE_CPU_RD && $urandom_range(0, 3) != 0)
            addr[15] = 1'b1;
        send_access(kind, addr, 8'($urandom), $urandom);
    endtask

    // five well-spaced writes that load one mapper register, other accesses sometimes interleaved
    task automatic serial_load();
        logic [1:0]  sel;
        logic [15:0] addr;
        sel = 2'($urandom_range(0, 3));
        for (int n = 0; n < 5; n++) begin
            addr = {1'b1, sel, 13'($urandom)};
            // only the address of the fifth write picks the register
            if (n < 4 && $urandom_range(0, 3) == 0)
                addr[14:13] = 2'($urandom);
            if ($urandom_range(0, 3) == 0)
                memory_access();
            cpu_write(addr, {1'b0, 7'($urandom)}, $urandom_range(2, 6));
        end
    endtask

    // hold the source until every result is back, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (words_due != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write: setup then access cycle, upper data bits random
    task automatic reg_write(input logic idx, input logic [5:0] count);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {26'($urandom), count};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // page rebuild runs after every count write
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int words_wanted);
        int stop_at;
        int pick;
        stop_at = words_sent + words_wanted;
        while (words_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                serial_load();
            else if (pick < 48)
                // reset write: bit 7 set, forces prg mode 3
                cpu_write(16'h8000 | 16'($urandom), 8'h80 | 8'($urandom),
                          $urandom_range(2, 9));
            else if (pick < 55)
                // close write, dropped by the mapper
                cpu_write(16'h8000 | 16'($urandom), 8'($urandom), $urandom_range(0, 1));
            else if (pick < 60)
                // stamp jump anywhere, any address
                cpu_write(16'($urandom), 8'($urandom), $urandom);
            else if (pick < 61)
                drain();
            else
                memory_access();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // page rebuild after reset
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // directed part, with the reset bank counts
        send_access(mmc1_pkg::MODE_CPU_RD, 16'h0000, 8'h00, 32'h0000_0000);  // below prg rom
        send_access(mmc1_pkg::MODE_CPU_RD, 16'h8000, 8'h00, 32'h0000_0000);
        send_access(mmc1_pkg::MODE_CPU_RD, 16'hC000, 8'h00, 32'h0000_0000);
        send_access(mmc1_pkg::MODE_CPU_RD, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        // too close after reset
        send_access(mmc1_pkg::MODE_CPU_WR, 16'h8000, 8'h01, 32'h0000_0001);
        // not a mapper write
        send_access(mmc1_pkg::MODE_CPU_WR, 16'h6000, 8'hFF, 32'h0000_0005);
        // shift register clear
        send_access(mmc1_pkg::MODE_CPU_WR, 16'h8000, 8'h80, 32'h0000_000A);
        // load 1 into the prg select, with one dropped write in the middle
        send_access(mmc1_pkg::MODE_CPU_WR, 16'hE000, 8'h01, 32'h0000_0014);
        send_access(mmc1_pkg::MODE_CPU_WR, 16'hE000, 8'h00, 32'h0000_0016);
        send_access(mmc1_pkg::MODE_CPU_WR, 16'hE000, 8'h01, 32'h0000_0017);
        send_access(mmc1_pkg::MODE_CPU_WR, 16'hE000, 8'h00, 32'h0000_0018);
        send_access(mmc1_pkg::MODE_CPU_WR, 16'hE000, 8'h00, 32'h0000_001A);
        send_access(mmc1_pkg::MODE_CPU_WR, 16'hFFFF, 8'h7E, 32'h0000_001C);
        send_access(mmc1_pkg::MODE_CPU_RD, 16'h8000, 8'h00, 32'h0000_0000);
        // last bank fixed
        send_access(mmc1_pkg::MODE_CPU_RD, 16'hC000, 8'h00, 32'h0000_0000);
        send_access(mmc1_pkg::MODE_PPU_RD, 16'h0000, 8'h00, 32'h0000_0000);
        send_access(mmc1_pkg::MODE_PPU_RD, 16'h1FFF, 8'h00, 32'h0000_0000);
        // chr rom write, no target
        send_access(mmc1_pkg::MODE_PPU_WR, 16'h0800, 8'h5A, 32'h0000_0000);
        send_access(mmc1_pkg::MODE_PPU_RD, 16'h2000, 8'h00, 32'h0000_0000);
        send_access(mmc1_pkg::MODE_PPU_WR, 16'h2C00, 8'hA5, 32'h0000_0000);
        // last nametable byte
        send_access(mmc1_pkg::MODE_PPU_RD, 16'h3EFF, 8'h00, 32'h0000_0000);
        // palette, no target
        send_access(mmc1_pkg::MODE_PPU_RD, 16'h3F00, 8'h00, 32'h0000_0000);
        send_access(mmc1_pkg::MODE_PPU_WR, 16'h3FFF, 8'hFF, 32'h0000_0000);
        // mirrors 0x0000
        send_access(mmc1_pkg::MODE_PPU_RD, 16'h4000, 8'h00, 32'h0000_0000);
        // clear at top stamp
        send_access(mmc1_pkg::MODE_CPU_WR, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        // random stamps carry on from here and wrap
        bus_stamp = 32'hFFFF_FFFF;

        for (int p = 0; p < PHASES; p++) begin
            drain();
            reg_write(mmc1_pkg::REG_PRG_COUNT, prg_counts[p]);
            reg_write(mmc1_pkg::REG_CHR_COUNT, chr_counts[p]);
            run_random(PHASE_WORDS);
        end
        drain();

        if (fail_total == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
hdl/mmc1_pkg.sv
hdl/mmc1_ctrl.sv
hdl/mmc1_dp.sv
hdl/mmc1_bank_mapper_unit.sv
hdl/mmc1_chk.sv
dv/mapper_checker.sv
dv/testbench.sv
